[hw/rtl/dtdi_pkg.sv]
// Package for the drift time to distance interpolator.
// Holds default sizes, codes and the sequencer state type; no dependencies.
`default_nettype none
package dtdi_pkg;
  localparam int MAX_POINTS_DEF = 64;
  localparam int TIME_BITS_DEF  = 16;
  localparam int DIST_BITS_DEF  = 16;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int NPTS_W     = 7;
  localparam int MAXD_W     = 16;
  localparam logic [CFG_IDX_W-1:0] REG_N_POINTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST = 1'b1;
  localparam logic [NPTS_W-1:0]    NPTS_RESET   = 7'd2;
  localparam logic [MAXD_W-1:0]    MAXD_RESET   = 16'hFFFF;

  // word kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHK0, ST_WALK, ST_FETCH, ST_FIN, ST_MUL, ST_DIV, ST_APPLY, ST_OUT
  } dtdi_state_t;
endpackage
`default_nettype wire

[hw/rtl/dtdi_in_if.sv]
// Input channel: valid/ready handshake with load and query payload.
// Stand-alone, no package use.
`default_nettype none
interface dtdi_in_if #(
  parameter int IDX_W     = 6,
  parameter int TIME_BITS = 16,
  parameter int DIST_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [IDX_W-1:0]     entry_index;
  logic [TIME_BITS-1:0] entry_time;
  logic [DIST_BITS-1:0] entry_distance;
  logic [15:0]          entry_diff_long;
  logic [15:0]          entry_diff_trans;
  logic [TIME_BITS-1:0] query_time;
  modport source (output valid, kind, entry_index, entry_time, entry_distance,
                  entry_diff_long, entry_diff_trans, query_time, input ready);
  modport sink   (input valid, kind, entry_index, entry_time, entry_distance,
                  entry_diff_long, entry_diff_trans, query_time, output ready);
endinterface
`default_nettype wire

[hw/rtl/dtdi_out_if.sv]
// Result channel: valid/ready handshake with the converted distance word.
// Stand-alone, no package use.
`default_nettype none
interface dtdi_out_if #(
  parameter int IDX_W     = 6,
  parameter int DIST_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [DIST_BITS-1:0] distance;
  logic [15:0]          diff_long;
  logic [15:0]          diff_trans;
  logic [IDX_W-1:0]     segment;
  logic                 extrapolated;
  logic                 below_start;
  modport source (output valid, distance, diff_long, diff_trans, segment,
                  extrapolated, below_start, input ready);
  modport sink   (input valid, distance, diff_long, diff_trans, segment,
                  extrapolated, below_start, output ready);
endinterface
`default_nettype wire

[hw/rtl/drift_time_to_distance_interp.sv]
// Drift time to distance interpolator, top level.
// Uses dtdi_pkg, dtdi_in_if, dtdi_out_if and dtdi_ram.
//
// Usage:
//  in_if  : one word per handshake. kind = load writes one table point
//           (time, distance, two diffusion values) and gives no result;
//           kind = query converts query_time and gives one result word.
//  out_if : distance clamped to [0, max_distance], diffusion of the upper
//           point, segment index and the extrapolated / below_start flags.
//  cfg    : write-only registers n_points (index 0) and max_distance (1).
//           Writing n_points or loading a point resets the segment cursor.
// Sequence: a load is written on acceptance. A query: point 0 is read
//  while idle and checked in the cycle after acceptance, then each walked point
//  is fetched, the final point is read, the product is formed, the restoring
//  divider forms the quotient and the clamp sets the word. Below-start words
//  skip the walk; zero-width ones skip the multiply, divide and clamp.
//  in_if.ready is low from acceptance of a query until its result is taken;
//  a stalled receiver holds the result word steady and the block waits.
// Reset (rst_n low, synchronous): cursor cleared, n_points = 2,
//  max_distance = 65535. Table contents are undefined until loaded.
`default_nettype none
module drift_time_to_distance_interp #(
  parameter int MAX_POINTS = dtdi_pkg::MAX_POINTS_DEF,
  parameter int TIME_BITS  = dtdi_pkg::TIME_BITS_DEF,
  parameter int DIST_BITS  = dtdi_pkg::DIST_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  dtdi_in_if.sink                              in_if,
  dtdi_out_if.source                           out_if,
  input  wire logic                            cfg_we,
  input  wire logic [dtdi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dtdi_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dtdi_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int WORD_W = 32 + DIST_BITS + TIME_BITS;
  localparam int PW = DIST_BITS + TIME_BITS;
  localparam int EW = PW + 1;
  localparam int DC_W = $clog2(PW + 1);

  dtdi_state_t state_r, state_nxt;

  logic [NPTS_W-1:0]    n_points_r;
  logic [MAXD_W-1:0]    max_dist_r;
  logic                 cur_valid_r, cur_valid_nxt;
  logic [IDX_W-1:0]     cur_r, cur_nxt;
  logic [TIME_BITS-1:0] up_t_r, up_t_nxt, lo_t_r, lo_t_nxt, t_r, t_nxt;
  logic [DIST_BITS-1:0] up_d_r, up_d_nxt, lo_d_r, lo_d_nxt;
  logic [DIST_BITS-1:0] mnum_r, mnum_nxt, base_r, base_nxt;
  logic [TIME_BITS-1:0] mdt_r, mdt_nxt, mden_r, mden_nxt, rem_r, rem_nxt;
  logic                 neg_r, neg_nxt;
  logic [PW-1:0]        qsh_r, qsh_nxt;
  logic [DC_W-1:0]      dcnt_r, dcnt_nxt;

  // result word registers
  logic [DIST_BITS-1:0] o_dist_r, o_dist_nxt;
  logic [15:0]          o_dl_r, o_dl_nxt, o_dt_r, o_dt_nxt;
  logic [IDX_W-1:0]     o_seg_r, o_seg_nxt;
  logic                 o_ext_r, o_ext_nxt, o_below_r, o_below_nxt;

  // table RAM
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_raddr;
  logic [WORD_W-1:0]    ram_wdata, ram_rdata;
  logic [TIME_BITS-1:0] rd_time;
  logic [DIST_BITS-1:0] rd_dist;
  logic [15:0]          rd_dl, rd_dt;

  assign ram_wdata = {in_if.entry_diff_trans, in_if.entry_diff_long,
                      in_if.entry_distance, in_if.entry_time};
  assign {rd_dt, rd_dl, rd_dist, rd_time} = ram_rdata;

  dtdi_ram #(.WIDTH(WORD_W), .DEPTH(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_if.entry_index),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // effective point count and last index
  logic [CNT_W-1:0] n_eff;
  logic [IDX_W-1:0] last_idx;
  always_comb begin
    if (n_points_r < NPTS_W'(2)) begin
      n_eff = CNT_W'(2);
    end else if (32'(n_points_r) > MAX_POINTS) begin
      n_eff = CNT_W'(MAX_POINTS);
    end else begin
      n_eff = CNT_W'(n_points_r);
    end
    last_idx = IDX_W'(n_eff - CNT_W'(1));
  end

  // walk decision and next index
  logic             walk_go;
  logic [IDX_W-1:0] next_idx;
  assign walk_go  = (t_r > up_t_r) && !(cur_valid_r && cur_r == last_idx);
  assign next_idx = cur_valid_r ? cur_r + IDX_W'(1) : '0;

  // segment arithmetic for the final step
  logic                 ext_w;
  logic [DIST_BITS:0]   num_s;
  logic [TIME_BITS:0]   den_s, dt_s;
  assign ext_w = (cur_r == last_idx) && (t_r > up_t_r);
  assign num_s = {1'b0, up_d_r} - {1'b0, lo_d_r};
  assign den_s = {1'b0, up_t_r} - {1'b0, lo_t_r};
  assign dt_s  = {1'b0, t_r} - {1'b0, (ext_w ? up_t_r : lo_t_r)};

  // divider step
  logic [TIME_BITS:0] rem_sh;
  logic               rem_ge;
  assign rem_sh = {rem_r, qsh_r[PW-1]};
  assign rem_ge = rem_sh >= {1'b0, mden_r};

  // clamp step
  logic [EW-1:0] q_e, base_e, max_e, sum_e, dif_e, fin_e;
  assign q_e    = EW'(qsh_r);
  assign base_e = EW'(base_r);
  assign max_e  = EW'(max_dist_r);
  assign sum_e  = base_e + q_e;
  assign dif_e  = base_e - q_e;
  always_comb begin
    if (neg_r) begin
      if (q_e >= base_e) begin
        fin_e = '0;
      end else if (dif_e > max_e) begin
        fin_e = max_e;
      end else begin
        fin_e = dif_e;
      end
    end else if (q_e > max_e || sum_e > max_e) begin
      fin_e = max_e;
    end else begin
      fin_e = sum_e;
    end
  end

  logic in_acc;
  assign in_acc = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == ST_IDLE);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cur_valid_nxt = cur_valid_r;
    cur_nxt       = cur_r;
    up_t_nxt      = up_t_r;
    lo_t_nxt      = lo_t_r;
    up_d_nxt      = up_d_r;
    lo_d_nxt      = lo_d_r;
    t_nxt         = t_r;
    mnum_nxt      = mnum_r;
    mdt_nxt       = mdt_r;
    mden_nxt      = mden_r;
    base_nxt      = base_r;
    neg_nxt       = neg_r;
    qsh_nxt       = qsh_r;
    rem_nxt       = rem_r;
    dcnt_nxt      = dcnt_r;
    o_dist_nxt    = o_dist_r;
    o_dl_nxt      = o_dl_r;
    o_dt_nxt      = o_dt_r;
    o_seg_nxt     = o_seg_r;
    o_ext_nxt     = o_ext_r;
    o_below_nxt   = o_below_r;
    ram_we        = 1'b0;
    ram_raddr     = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_if.kind == KIND_LOAD) begin
            ram_we        = 1'b1;
            cur_valid_nxt = 1'b0;
            up_t_nxt      = '0;
            lo_t_nxt      = '0;
          end else begin
            t_nxt     = in_if.query_time;
            state_nxt = ST_CHK0;
          end
        end
      end
      ST_CHK0: begin
        if (t_r <= rd_time) begin
          o_dist_nxt  = '0;
          o_dl_nxt    = rd_dl;
          o_dt_nxt    = rd_dt;
          o_seg_nxt   = '0;
          o_ext_nxt   = 1'b0;
          o_below_nxt = 1'b1;
          state_nxt   = ST_OUT;
        end else begin
          // rewind when the time falls below the segment or past the count
          if (cur_valid_r && (t_r <= lo_t_r || CNT_W'(cur_r) >= n_eff)) begin
            cur_valid_nxt = 1'b0;
            up_t_nxt      = '0;
          end
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_go) begin
          ram_raddr = next_idx;
          state_nxt = ST_FETCH;
        end else begin
          ram_raddr = cur_r;
          state_nxt = ST_FIN;
        end
      end
      ST_FETCH: begin
        cur_nxt       = next_idx;
        cur_valid_nxt = 1'b1;
        lo_d_nxt      = up_d_r;
        lo_t_nxt      = up_t_r;
        up_t_nxt      = rd_time;
        up_d_nxt      = rd_dist;
        state_nxt     = ST_WALK;
      end
      ST_FIN: begin
        o_dl_nxt    = rd_dl;
        o_dt_nxt    = rd_dt;
        o_seg_nxt   = cur_r;
        o_ext_nxt   = ext_w;
        o_below_nxt = 1'b0;
        if (up_t_r == lo_t_r) begin
          o_dist_nxt = (EW'(up_d_r) > max_e) ? DIST_BITS'(max_dist_r) : up_d_r;
          state_nxt  = ST_OUT;
        end else begin
          mnum_nxt  = num_s[DIST_BITS] ? DIST_BITS'(-num_s) : num_s[DIST_BITS-1:0];
          mdt_nxt   = dt_s[TIME_BITS] ? TIME_BITS'(-dt_s) : dt_s[TIME_BITS-1:0];
          mden_nxt  = den_s[TIME_BITS] ? TIME_BITS'(-den_s) : den_s[TIME_BITS-1:0];
          neg_nxt   = num_s[DIST_BITS] ^ dt_s[TIME_BITS] ^ den_s[TIME_BITS];
          base_nxt  = ext_w ? up_d_r : lo_d_r;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        qsh_nxt   = PW'(mnum_r * mdt_r);
        rem_nxt   = '0;
        dcnt_nxt  = DC_W'(PW);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // one quotient bit per cycle, restoring
        rem_nxt  = rem_ge ? TIME_BITS'(rem_sh - {1'b0, mden_r}) : TIME_BITS'(rem_sh);
        qsh_nxt  = {qsh_r[PW-2:0], rem_ge};
        dcnt_nxt = dcnt_r - DC_W'(1);
        if (dcnt_r == DC_W'(1)) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        o_dist_nxt = DIST_BITS'(fin_e);
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (out_if.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // n_points write starts a fresh table walk
    if (cfg_we && cfg_index == REG_N_POINTS) begin
      cur_valid_nxt = 1'b0;
      up_t_nxt      = '0;
      lo_t_nxt      = '0;
    end
  end

  // control and cursor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_valid_r <= 1'b0;
      up_t_r      <= '0;
      lo_t_r      <= '0;
      up_d_r      <= '0;
      lo_d_r      <= '0;
      n_points_r  <= NPTS_RESET;
      max_dist_r  <= MAXD_RESET;
    end else begin
      state_r     <= state_nxt;
      cur_valid_r <= cur_valid_nxt;
      up_t_r      <= up_t_nxt;
      lo_t_r      <= lo_t_nxt;
      up_d_r      <= up_d_nxt;
      lo_d_r      <= lo_d_nxt;
      if (cfg_we && cfg_index == REG_N_POINTS) begin
        n_points_r <= cfg_data[NPTS_W-1:0];
      end
      if (cfg_we && cfg_index == REG_MAX_DIST) begin
        max_dist_r <= cfg_data[MAXD_W-1:0];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    t_r       <= t_nxt;
    mnum_r    <= mnum_nxt;
    mdt_r     <= mdt_nxt;
    mden_r    <= mden_nxt;
    base_r    <= base_nxt;
    neg_r     <= neg_nxt;
    qsh_r     <= qsh_nxt;
    rem_r     <= rem_nxt;
    dcnt_r    <= dcnt_nxt;
    o_dist_r  <= o_dist_nxt;
    o_dl_r    <= o_dl_nxt;
    o_dt_r    <= o_dt_nxt;
    o_seg_r   <= o_seg_nxt;
    o_ext_r   <= o_ext_nxt;
    o_below_r <= o_below_nxt;
  end

  assign out_if.valid        = (state_r == ST_OUT);
  assign out_if.distance     = o_dist_r;
  assign out_if.diff_long    = o_dl_r;
  assign out_if.diff_trans   = o_dt_r;
  assign out_if.segment      = o_seg_r;
  assign out_if.extrapolated = o_ext_r;
  assign out_if.below_start  = o_below_r;
endmodule
`default_nettype wire

[hw/rtl/dtdi_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module dtdi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[verif/tb_dtdi_ifs.sv]
// Note: the channel interfaces dtdi_in_if and dtdi_out_if come with the RTL.
// This file holds only shared testbench types; it uses no package.
`timescale 1ns / 100ps
package tb_dtdi_types;
  typedef struct packed {
    logic [15:0] distance;
    logic [15:0] diff_long;
    logic [15:0] diff_trans;
    logic [5:0]  segment;
    logic        extrapolated;
    logic        below_start;
  } dist_word_t;
  typedef struct packed {
    logic        kind;
    logic [5:0]  entry_index;
    logic [15:0] entry_time;
    logic [15:0] entry_distance;
    logic [15:0] entry_diff_long;
    logic [15:0] entry_diff_trans;
    logic [15:0] query_time;
  } in_word_t;
endpackage

[verif/tb_drift_time_to_distance_interp.sv]
// Testbench for drift_time_to_distance_interp: loads tables, queries drift times
// and checks every result word against an in-bench table interpolator.
// Depends on dtdi_pkg, dtdi_in_if, dtdi_out_if and tb_dtdi_types.
`timescale 1ns / 100ps
module tb_drift_time_to_distance_interp;
  import dtdi_pkg::*;
  import tb_dtdi_types::*;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dtdi_in_if  in_if ();
  dtdi_out_if out_if ();

  drift_time_to_distance_interp dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [15:0] tbl_time [64];
  logic [15:0] tbl_dist [64];
  logic [15:0] tbl_dl [64];
  logic [15:0] tbl_dt [64];
  int          seg_cur;
  logic [15:0] seg_hi_t, seg_lo_t, seg_hi_d, seg_lo_d;
  int          pts_cfg;
  logic [15:0] dist_clamp;
  bit          loaded [64];

  in_word_t   word_q [$];
  dist_word_t expected_q [$];
  int  errors;
  int  idle_cycles;
  bit  quiet;       // no idling on either side
  bit  hold_sink;   // long receiver hold-off request
  int  hold_cnt;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  // walking table interpolator
  function automatic dist_word_t convert_time(input logic [15:0] t);
    dist_word_t r;
    int n;
    longint num, dt, den, q, base, res;
    bit ext;
    n = (pts_cfg < 2) ? 2 : (pts_cfg > 64 ? 64 : pts_cfg);
    r = '0;
    if (t <= tbl_time[0]) begin
      r.diff_long = tbl_dl[0];
      r.diff_trans = tbl_dt[0];
      r.below_start = 1'b1;
      return r;
    end
    if (seg_cur != -1 && (t <= seg_lo_t || seg_cur >= n)) begin
      seg_cur = -1;
      seg_hi_t = '0;
    end
    while (t > seg_hi_t && seg_cur != n - 1) begin
      seg_cur++;
      seg_lo_d = seg_hi_d;
      seg_lo_t = seg_hi_t;
      seg_hi_t = tbl_time[seg_cur];
      seg_hi_d = tbl_dist[seg_cur];
    end
    ext = (seg_cur == n - 1) && (t > seg_hi_t);
    if (seg_hi_t == seg_lo_t) begin
      res = seg_hi_d;
    end else begin
      num = longint'(seg_hi_d) - longint'(seg_lo_d);
      den = longint'(seg_hi_t) - longint'(seg_lo_t);
      base = ext ? longint'(seg_hi_d) : longint'(seg_lo_d);
      dt = longint'(t) - (ext ? longint'(seg_hi_t) : longint'(seg_lo_t));
      // truncate toward zero on magnitudes
      q = ((num < 0 ? -num : num) * (dt < 0 ? -dt : dt)) / (den < 0 ? -den : den);
      if ((num < 0) ^ (dt < 0) ^ (den < 0)) res = (q >= base) ? 0 : base - q;
      else res = base + q;
    end
    if (res > dist_clamp) res = dist_clamp;
    r.distance = res[15:0];
    r.diff_long = tbl_dl[seg_cur];
    r.diff_trans = tbl_dt[seg_cur];
    r.segment = seg_cur[5:0];
    r.extrapolated = ext;
    return r;
  endfunction

  function automatic void accept_word(input in_word_t w);
    if (w.kind == KIND_LOAD) begin
      tbl_time[w.entry_index] = w.entry_time;
      tbl_dist[w.entry_index] = w.entry_distance;
      tbl_dl[w.entry_index] = w.entry_diff_long;
      tbl_dt[w.entry_index] = w.entry_diff_trans;
      seg_cur = -1;
      seg_hi_t = '0;
      seg_lo_t = '0;
    end else begin
      expected_q.push_back(convert_time(w.query_time));
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        accept_word({in_if.kind, in_if.entry_index, in_if.entry_time,
                     in_if.entry_distance, in_if.entry_diff_long,
                     in_if.entry_diff_trans, in_if.query_time});
      end
      if (!in_if.valid || in_if.ready) begin
        if (word_q.size() > 0 && (quiet || $urandom_range(99) >= 12)) begin
          in_word_t w;
          w = word_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.kind <= w.kind;
          in_if.entry_index <= w.entry_index;
          in_if.entry_time <= w.entry_time;
          in_if.entry_distance <= w.entry_distance;
          in_if.entry_diff_long <= w.entry_diff_long;
          in_if.entry_diff_trans <= w.entry_diff_trans;
          in_if.query_time <= w.query_time;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_cnt <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        dist_word_t got, exp_w;
        got = {out_if.distance, out_if.diff_long, out_if.diff_trans, out_if.segment,
               out_if.extrapolated, out_if.below_start};
        if (expected_q.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          exp_w = expected_q.pop_front();
          if (got.distance !== exp_w.distance)
            report($sformatf("distance %0d exp %0d", got.distance, exp_w.distance));
          if (got.diff_long !== exp_w.diff_long)
            report($sformatf("diff_long %0h exp %0h", got.diff_long, exp_w.diff_long));
          if (got.diff_trans !== exp_w.diff_trans)
            report($sformatf("diff_trans %0h exp %0h", got.diff_trans, exp_w.diff_trans));
          if (got.segment !== exp_w.segment)
            report($sformatf("segment %0d exp %0d", got.segment, exp_w.segment));
          if (got.extrapolated !== exp_w.extrapolated)
            report($sformatf("extrapolated %b exp %b", got.extrapolated, exp_w.extrapolated));
          if (got.below_start !== exp_w.below_start)
            report($sformatf("below_start %b exp %b", got.below_start, exp_w.below_start));
        end
      end
      if (hold_sink && hold_cnt < 400) begin
        hold_cnt <= hold_cnt + 1;
        out_if.ready <= 1'b0;
      end else begin
        if (!hold_sink) hold_cnt <= 0;
        out_if.ready <= quiet || ($urandom_range(99) >= 12);
      end
    end
  end

  // watchdog on stalled handshakes
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic in_word_t load_word(input int idx, input logic [15:0] t,
                                         input logic [15:0] d);
    in_word_t w;
    w = '0;
    w.kind = KIND_LOAD;
    w.entry_index = idx[5:0];
    w.entry_time = t;
    w.entry_distance = d;
    w.entry_diff_long = 16'($urandom);
    w.entry_diff_trans = 16'($urandom);
    w.query_time = 16'($urandom);
    return w;
  endfunction

  function automatic in_word_t query_word(input logic [15:0] t);
    in_word_t w;
    w = in_word_t'(($bits(in_word_t))'({$urandom, $urandom, $urandom}));
    w.kind = KIND_QUERY;
    w.query_time = t;
    return w;
  endfunction

  task automatic drain();
    while (word_q.size() > 0 || expected_q.size() > 0 || in_if.valid) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_N_POINTS) begin
      pts_cfg = val[6:0];
      seg_cur = -1;
      seg_hi_t = '0;
      seg_lo_t = '0;
    end else begin
      dist_clamp = val;
    end
  endtask

  // load a table of n points with random, mostly rising times
  task automatic load_table(input int n, input bit rising);
    int t, d;
    t = $urandom_range(0, 200);
    for (int i = 0; i < n; i++) begin
      d = rising ? $urandom_range(0, 65535) : $urandom;
      word_q.push_back(load_word(i, 16'(t), 16'(d)));
      loaded[i] = 1'b1;
      if (rising) t = t + (($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3000));
      else t = $urandom_range(0, 65535);
      if (t > 65535) t = 65535;
    end
  endtask

  // random query run; cursor rewinds happen on descending times
  task automatic query_run(input int cnt);
    logic [15:0] t;
    t = 16'($urandom_range(0, 2000));
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(4) == 0) t = 16'($urandom);
      else t = t + 16'($urandom_range(0, 1500));
      word_q.push_back(query_word(t));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.kind = 1'b0;
    in_if.entry_index = '0;
    in_if.entry_time = '0;
    in_if.entry_distance = '0;
    in_if.entry_diff_long = '0;
    in_if.entry_diff_trans = '0;
    in_if.query_time = '0;
    out_if.ready = 1'b0;
    errors = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    hold_sink = 1'b0;
    seg_cur = -1;
    seg_hi_t = '0; seg_lo_t = '0; seg_hi_d = '0; seg_lo_d = '0;
    pts_cfg = 2;
    dist_clamp = 16'hFFFF;
    for (int i = 0; i < 64; i++) begin
      tbl_time[i] = '0; tbl_dist[i] = '0; tbl_dl[i] = '0; tbl_dt[i] = '0;
      loaded[i] = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: two-point table at reset count, extremes, zero-width, falling
    word_q.push_back(load_word(0, 16'd100, 16'd0));
    word_q.push_back(load_word(1, 16'd100, 16'hFFFF));
    word_q.push_back(load_word(2, 16'd1100, 16'd500));
    word_q.push_back(load_word(63, 16'hFFFF, 16'hFFFF));
    word_q.push_back(query_word(16'd0));
    word_q.push_back(query_word(16'd100));
    word_q.push_back(query_word(16'd101));
    word_q.push_back(query_word(16'hFFFF));
    word_q.push_back(load_word(1, 16'd1100, 16'd4000));
    word_q.push_back(query_word(16'd600));
    word_q.push_back(query_word(16'd1100));
    word_q.push_back(query_word(16'd101));
    word_q.push_back(query_word(16'hFFFF));
    drain();
    // falling distance across segments, extrapolation down to zero
    write_reg(REG_N_POINTS, 16'd3);
    write_reg(REG_MAX_DIST, 16'd0);
    word_q.push_back(load_word(2, 16'd200, 16'd0));
    word_q.push_back(query_word(16'd1000));
    drain();
    write_reg(REG_MAX_DIST, 16'hFFFF);
    word_q.push_back(query_word(16'd150));
    word_q.push_back(query_word(16'd1500));
    word_q.push_back(query_word(16'hFFFF));
    word_q.push_back(query_word(16'd120));
    drain();

    // random phases over several counts and clamps, incl. extremes
    for (int ph = 0; ph < 12; ph++) begin
      int n;
      case (ph % 6)
        0: n = 64;
        1: n = 2;
        2: n = 0;
        3: n = 127;
        default: n = $urandom_range(2, 20);
      endcase
      quiet = (ph == 4);
      write_reg(REG_N_POINTS, 16'(n));
      write_reg(REG_MAX_DIST, (ph % 3 == 0) ? 16'hFFFF : 16'($urandom));
      load_table((n < 2) ? 2 : (n > 64 ? 64 : n), ph != 7);
      if (ph == 5) hold_sink = 1'b1;
      query_run(ph == 0 ? 80 : 30);
      if (ph == 3) begin
        // sender waits for every result before continuing
        while (word_q.size() > 0 || in_if.valid) @(posedge clk);
        while (expected_q.size() > 0) @(posedge clk);
        query_run(10);
      end
      drain();
      hold_sink = 1'b0;
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
